@@ rtl/core/xkb_pkg.sv @@
// xkb_pkg: shared constants, types and the base64 alphabet for the
// xor keystream base64 encoder; no dependencies
package xkb_pkg;

	// number of key bytes used cyclically
	localparam int KEY_LENGTH = 12;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_0_TO_3  = 2'd0;
	localparam logic [1:0] REG_KEY_4_TO_7  = 2'd1;
	localparam logic [1:0] REG_KEY_8_TO_11 = 2'd2;

	// ascii codes used by the encoder
	localparam logic [6:0] CHAR_PAD   = 7'h3D; // '='
	localparam logic [6:0] CHAR_UPPER = 7'h41; // 'A'
	localparam logic [6:0] CHAR_LOWER = 7'h61; // 'a'
	localparam logic [6:0] CHAR_DIGIT = 7'h30; // '0'
	localparam logic [6:0] CHAR_PLUS  = 7'h2B; // '+'
	localparam logic [6:0] CHAR_SLASH = 7'h2F; // '/'

	// one xored byte with the group state it meets
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [1:0] phase;
		logic [3:0] leftover;
	} xkb_byte_t;

	// up to four characters caused by one byte, slot 0 goes out first
	typedef struct packed {
		logic [3:0][6:0] chars;
		logic [3:0]      lasts;
		logic [2:0]      count;
	} xkb_chars_t;

	// standard base64 alphabet
	function automatic logic [6:0] sextet(input logic [5:0] v);
		logic [6:0] w;
		w = {1'b0, v};
		if (v < 6'd26)
			sextet = CHAR_UPPER + w;
		else if (v < 6'd52)
			sextet = CHAR_LOWER + w - 7'd26;
		else if (v < 6'd62)
			sextet = CHAR_DIGIT + w - 7'd52;
		else if (v == 6'd62)
			sextet = CHAR_PLUS;
		else
			sextet = CHAR_SLASH;
	endfunction

endpackage

@@ rtl/core/xkb_front.sv @@
// xkb_front: key registers, key position and group state; xors each
// accepted byte and registers it for encoding; uses xkb_pkg
module xkb_front import xkb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        accept,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic        advance,
	output logic        valid_s1,
	output xkb_byte_t   byte_s1
);

	logic [31:0] key0_q, key1_q, key2_q;
	logic [3:0]  pos_q;
	logic [1:0]  phase_q;
	logic [3:0]  leftover_q;

	logic [31:0] key_word;
	logic [7:0]  key_byte;
	logic [7:0]  xored;
	logic [4:0]  pos_inc;
	logic [3:0]  pos_next;
	logic [1:0]  phase_next;
	logic [3:0]  leftover_next;

	// key byte select, indexes twelve and up read as zero
	always_comb begin
		case (pos_q[3:2])
			2'd0:    key_word = key0_q;
			2'd1:    key_word = key1_q;
			2'd2:    key_word = key2_q;
			default: key_word = '0;
		endcase
		case (pos_q[1:0])
			2'd0:    key_byte = key_word[7:0];
			2'd1:    key_byte = key_word[15:8];
			2'd2:    key_byte = key_word[23:16];
			default: key_byte = key_word[31:24];
		endcase
	end

	assign xored = in_byte ^ key_byte;

	// next position and group state
	always_comb begin
		pos_inc = {1'b0, pos_q} + 5'd1;
		pos_next = (pos_inc >= 5'(KEY_LENGTH)) ? 4'd0 : pos_inc[3:0];
		case (phase_q)
			2'd1: begin
				phase_next    = 2'd2;
				leftover_next = xored[3:0];
			end
			2'd2: begin
				phase_next    = 2'd0;
				leftover_next = 4'd0;
			end
			default: begin
				phase_next    = 2'd1;
				leftover_next = {2'b00, xored[1:0]};
			end
		endcase
		if (in_last) begin
			pos_next      = 4'd0;
			phase_next    = 2'd0;
			leftover_next = 4'd0;
		end
	end

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_0_TO_3:  key0_q <= cfg_wdata;
				REG_KEY_4_TO_7:  key1_q <= cfg_wdata;
				REG_KEY_8_TO_11: key2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			phase_q    <= '0;
			leftover_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (accept) begin
				pos_q      <= pos_next;
				phase_q    <= phase_next;
				leftover_q <= leftover_next;
			end
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1.data     <= xored;
			byte_s1.last     <= in_last;
			byte_s1.phase    <= phase_q;
			byte_s1.leftover <= leftover_q;
		end
	end

endmodule

@@ rtl/core/xkb_encode.sv @@
// xkb_encode: turns one xored byte and its group state into up to four
// base64 characters with padding; uses xkb_pkg
module xkb_encode import xkb_pkg::*; (
	input  xkb_byte_t  byte_in,
	output xkb_chars_t chars_out
);

	logic [7:0] b;

	assign b = byte_in.data;

	// character selection per group phase
	always_comb begin
		chars_out.chars = '0;
		chars_out.lasts = '0;
		case (byte_in.phase)
			2'd1: begin
				chars_out.chars[0] = sextet({byte_in.leftover[1:0], b[7:4]});
				if (byte_in.last) begin
					chars_out.chars[1] = sextet({b[3:0], 2'b00});
					chars_out.chars[2] = CHAR_PAD;
					chars_out.lasts[2] = 1'b1;
					chars_out.count    = 3'd3;
				end else begin
					chars_out.count    = 3'd1;
				end
			end
			2'd2: begin
				chars_out.chars[0] = sextet({byte_in.leftover, b[7:6]});
				chars_out.chars[1] = sextet(b[5:0]);
				chars_out.lasts[1] = byte_in.last;
				chars_out.count    = 3'd2;
			end
			default: begin
				chars_out.chars[0] = sextet(b[7:2]);
				if (byte_in.last) begin
					chars_out.chars[1] = sextet({b[1:0], 4'b0000});
					chars_out.chars[2] = CHAR_PAD;
					chars_out.chars[3] = CHAR_PAD;
					chars_out.lasts[3] = 1'b1;
					chars_out.count    = 3'd4;
				end else begin
					chars_out.count    = 3'd1;
				end
			end
		endcase
	end

endmodule

@@ rtl/core/xkb_outbuf.sv @@
// xkb_outbuf: result register holding the characters of one byte and
// shifting them out one per transaction; uses xkb_pkg
module xkb_outbuf import xkb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load_valid,
	input  xkb_chars_t load_chars,
	output logic       load,
	output logic       tvalid,
	input  logic       tready,
	output logic [6:0] out_char,
	output logic       out_last
);

	logic [3:0][6:0] chars_q;
	logic [3:0]      lasts_q;
	logic [2:0]      count_q;
	logic            pop;

	assign tvalid   = (count_q != 3'd0);
	assign pop      = tvalid && tready;
	assign load     = load_valid && ((count_q == 3'd0) || ((count_q == 3'd1) && tready));
	assign out_char = chars_q[0];
	assign out_last = lasts_q[0];

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (load)
			count_q <= load_chars.count;
		else if (pop)
			count_q <= count_q - 3'd1;
	end

	// character slots, shift toward slot 0 on each transaction
	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= load_chars.chars;
			lasts_q <= load_chars.lasts;
		end else if (pop) begin
			chars_q <= {7'd0, chars_q[3:1]};
			lasts_q <= {1'b0, lasts_q[3:1]};
		end
	end

endmodule

@@ rtl/core/xor_keystream_base64_encoder.sv @@
// xor_keystream_base64_encoder: top level of the xor keystream base64
// encoder; uses xkb_pkg, xkb_front, xkb_encode and xkb_outbuf
//
// Message bytes enter on the s_axis channel, s_axis_tlast on the final
// byte of a message. Each byte is xored with the next byte of a 12-byte
// key, used cyclically, and the stream is base64 encoded. ASCII
// characters leave on the m_axis channel, m_axis_tlast on the final
// character of a message (the last one, or the last '=' of padding).
// The key is written through cfg_we/cfg_index/cfg_wdata; the user
// must do so only while idle, as the block does not enforce it. A
// write takes effect from the next accepted byte. An accepted byte
// is registered in the input stage, encoded combinationally and
// loaded into the result register that drives m_axis. Each byte
// causes one to four characters, 1 or 2 mid-message and 2 to 4 on a
// final byte; the output side sends one per cycle while m_axis_tready
// is high. A registered input stage and a four-slot result register
// let a new byte be taken while the previous characters drain.
// Reset clears the key to zero and returns the key position and group
// phase to the start. When the receiver stalls, the result register
// holds its character, the input stage fills and s_axis_tready drops.
module xor_keystream_base64_encoder import xkb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  logic        s_axis_tlast,  // in_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [6:0] out_char, [7] zero
	output logic        m_axis_tlast   // out_last
);

	logic       accept;
	logic       advance;
	logic       valid_s1;
	xkb_byte_t  byte_s1;
	xkb_chars_t chars;
	logic [6:0] out_char;

	// input stage is free when empty or moving on this cycle
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	xkb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	xkb_encode u_encode (
		.byte_in   (byte_s1),
		.chars_out (chars)
	);

	xkb_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_chars (chars),
		.load       (advance),
		.tvalid     (m_axis_tvalid),
		.tready     (m_axis_tready),
		.out_char   (out_char),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_char};

endmodule

@@ rtl/core/xkb_checker.sv @@
// xkb_checker: port-level checks for the xor keystream base64 encoder,
// bound to the top level; uses xkb_pkg
module xkb_checker import xkb_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	logic pad_pending_q;

	// set after a padding character that does not end the message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pad_pending_q <= 1'b0;
		else if (m_axis_tvalid && m_axis_tready)
			pad_pending_q <= (m_axis_tdata[6:0] == CHAR_PAD) && !m_axis_tlast;
	end

	// stalled transaction holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	// characters are seven-bit ascii
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[7])
		else $error("output character above seven bits");

	// a padding character is followed by another one up to the end
	a_pad_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && pad_pending_q |-> m_axis_tdata[6:0] == CHAR_PAD)
		else $error("data character after padding");

	// after a non-final padding character, a message ends on padding
	a_pad_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && pad_pending_q |->
		m_axis_tdata[6:0] == CHAR_PAD)
		else $error("message ended on data after padding");

endmodule

bind xor_keystream_base64_encoder xkb_checker u_xkb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
